// ===== hdl/cpu_bus_decoder_with_oam_dma_defines.svh =====
// assertion macros shared by the bus decoder rtl
`ifndef CPU_BUS_DECODER_WITH_OAM_DMA_DEFINES_SVH
`define CPU_BUS_DECODER_WITH_OAM_DMA_DEFINES_SVH

`ifndef SYNTHESIS

// check on every clock edge outside reset
`define CBD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// check on every clock edge, reset included
`define CBD_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`else

`define CBD_ASSERT(lbl, prop, msg)
`define CBD_ASSERT_ALWAYS(lbl, prop, msg)

`endif

`endif

// ===== hdl/cbd_pkg.sv =====
// types and constants of the cpu bus decoder with sprite dma
package cbd_pkg;

  // command codes
  localparam logic [1:0] CMD_READ  = 2'd0;
  localparam logic [1:0] CMD_WRITE = 2'd1;
  localparam logic [1:0] CMD_TICK  = 2'd2;

  // target codes
  localparam logic [2:0] TGT_NONE  = 3'd0;
  localparam logic [2:0] TGT_RAM   = 3'd1;
  localparam logic [2:0] TGT_VIDEO = 3'd2;
  localparam logic [2:0] TGT_AUDIO = 3'd3;
  localparam logic [2:0] TGT_OAM   = 3'd4;
  localparam logic [2:0] TGT_PAD1  = 3'd5;
  localparam logic [2:0] TGT_PAD2  = 3'd6;
  localparam logic [2:0] TGT_CART  = 3'd7;

  // address map
  localparam logic [15:0] ADDR_RAM_END   = 16'h1FFF;
  localparam logic [15:0] ADDR_VIDEO_END = 16'h3FFF;
  localparam logic [15:0] ADDR_APU_END   = 16'h4013;
  localparam logic [15:0] ADDR_OAM_DMA   = 16'h4014;
  localparam logic [15:0] ADDR_STATUS    = 16'h4015;
  localparam logic [15:0] ADDR_PAD1      = 16'h4016;
  localparam logic [15:0] ADDR_PAD2      = 16'h4017;
  localparam logic [15:0] ADDR_CART      = 16'h8000;

  // open-bus merge masks
  localparam logic [7:0] PAD_OB_MASK     = 8'hE0;
  localparam logic [7:0] PAD_EXT_MASK    = 8'h1F;
  localparam logic [7:0] STATUS_OB_MASK  = 8'h20;
  localparam logic [7:0] STATUS_EXT_MASK = 8'hDF;

  localparam logic [7:0] RAM_FILL = 8'hFF;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [15:0] addr;
    logic [7:0]  wdata;
    logic [7:0]  ext_data;
    logic        cycle_odd;
    logic [7:0]  oam_base;
  } req_t;

  typedef struct packed {
    logic [7:0]  rdata;
    logic [2:0]  target;
    logic        ext_write;
    logic [15:0] bus_addr;
    logic        oam_write;
    logic [7:0]  oam_index;
    logic [7:0]  oam_data;
    logic        dma_busy;
    logic        dmc_flag;
  } rsp_t;

endpackage

// ===== hdl/cpu_bus_decoder_with_oam_dma.sv =====
// CPU bus decoder with sprite dma: one transaction per cycle (read, write or
// dma tick) is decoded against the address map, updates the open-bus latch and
// the dma sequencer at acceptance, and yields one result transaction through
// the middle stage and the result register, the work ram read landing in
// between through the ram's registered port. A new transaction can be taken
// every cycle while results keep flowing, and one more is taken while a
// result waits on a stalled output. After reset the work ram is filled with
// 0xFF, one byte a cycle, and the request side stalls until the fill is done.
`include "cpu_bus_decoder_with_oam_dma_defines.svh"

module cpu_bus_decoder_with_oam_dma #(
  parameter int RAM_BYTES = 2048
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_stall,
  input  cbd_pkg::req_t req,
  output logic          rsp_valid,
  input  logic          rsp_stall,
  output cbd_pkg::rsp_t rsp
);

  localparam int RA_W = $clog2(RAM_BYTES);
  localparam int MW   = 18;

  // mirrored ram slot: (a & 0x1FFF) mod RAM_BYTES by conditional subtraction
  function automatic logic [RA_W-1:0] ram_slot(input logic [15:0] a);
    logic [MW-1:0] v;
    v = {{(MW-13){1'b0}}, a[12:0]};
    for (int k = 4; k >= 0; k--) begin
      if (v >= MW'(RAM_BYTES << k)) begin
        v = v - MW'(RAM_BYTES << k);
      end
    end
    return RA_W'(v);
  endfunction

  // state
  logic [7:0]      open_bus, open_bus_next;
  logic [7:0]      dma_page, dma_page_next;
  logic [7:0]      dma_index, dma_index_next;
  logic [7:0]      dma_byte, dma_byte_next;
  logic            dma_wait, dma_wait_next;
  logic            dma_on, dma_on_next;
  logic            dmc_on, dmc_on_next;
  logic            ram_rd_d1;
  logic            rd_dma_d1;
  logic            clr_done;
  logic [RA_W-1:0] clr_addr;

  // middle stage and result register
  logic            b_valid;
  cbd_pkg::rsp_t   b_res;
  logic            b_from_ram;
  cbd_pkg::rsp_t   b_out;

  // decode signals
  logic            acc;
  logic            b_move;
  logic [7:0]      ob_eff;
  logic [7:0]      db_eff;
  cbd_pkg::rsp_t   res;
  logic [15:0]     rd_a;
  logic            do_read;
  logic            is_fetch;
  logic            from_ram;
  logic            ob_we;
  logic [7:0]      ob_val;
  logic            ram_wr;
  logic [RA_W-1:0] slot;

  // ram ports
  logic            ram_we;
  logic [RA_W-1:0] ram_waddr;
  logic [7:0]      ram_wdata;
  logic            ram_re;
  logic [7:0]      ram_q;

  // handshake
  assign acc       = req_valid && !req_stall;
  assign b_move    = b_valid && (!rsp_valid || !rsp_stall);
  assign req_stall = !clr_done || (b_valid && !b_move);

  // latched bytes, with the ram read of the previous cycle folded in
  assign ob_eff = ram_rd_d1 ? ram_q : open_bus;
  assign db_eff = (ram_rd_d1 && rd_dma_d1) ? ram_q : dma_byte;

  // fetch address comes from the dma sequencer on ticks
  assign is_fetch = (req.cmd == cbd_pkg::CMD_TICK) && dma_on && !dma_wait && !req.cycle_odd;
  assign do_read  = (req.cmd == cbd_pkg::CMD_READ) || is_fetch;
  assign rd_a     = (req.cmd == cbd_pkg::CMD_READ) ? req.addr : {dma_page, dma_index};
  assign slot     = ram_slot((req.cmd == cbd_pkg::CMD_WRITE) ? req.addr : rd_a);

  // decode, open bus and dma sequencing for the incoming transaction
  always_comb begin
    res            = '0;
    from_ram       = 1'b0;
    ob_we          = 1'b0;
    ob_val         = ob_eff;
    ram_wr         = 1'b0;
    dma_page_next  = dma_page;
    dma_index_next = dma_index;
    dma_wait_next  = dma_wait;
    dma_on_next    = dma_on;
    dmc_on_next    = dmc_on;

    if (do_read) begin
      res.bus_addr = rd_a;
      priority if (rd_a <= cbd_pkg::ADDR_RAM_END) begin
        res.target = cbd_pkg::TGT_RAM;
        from_ram   = 1'b1;
      end else if (rd_a <= cbd_pkg::ADDR_VIDEO_END) begin
        res.target = cbd_pkg::TGT_VIDEO;
        ob_we      = 1'b1;
        ob_val     = req.ext_data;
      end else if (rd_a == cbd_pkg::ADDR_OAM_DMA) begin
        res.target = cbd_pkg::TGT_OAM;
        ob_we      = 1'b1;
        ob_val     = req.ext_data;
      end else if (rd_a <= cbd_pkg::ADDR_APU_END) begin
        res.target = cbd_pkg::TGT_AUDIO;
        ob_we      = 1'b1;
        ob_val     = req.ext_data;
      end else if (rd_a == cbd_pkg::ADDR_STATUS) begin
        res.target = cbd_pkg::TGT_AUDIO;
      end else if (rd_a == cbd_pkg::ADDR_PAD1) begin
        res.target = cbd_pkg::TGT_PAD1;
        ob_we      = 1'b1;
        ob_val     = (ob_eff & cbd_pkg::PAD_OB_MASK) | (req.ext_data & cbd_pkg::PAD_EXT_MASK);
      end else if (rd_a == cbd_pkg::ADDR_PAD2) begin
        res.target = cbd_pkg::TGT_PAD2;
        ob_we      = 1'b1;
        ob_val     = (ob_eff & cbd_pkg::PAD_OB_MASK) | (req.ext_data & cbd_pkg::PAD_EXT_MASK);
      end else if (rd_a >= cbd_pkg::ADDR_CART) begin
        res.target = cbd_pkg::TGT_CART;
        ob_we      = 1'b1;
        ob_val     = req.ext_data;
      end else begin
        res.target = cbd_pkg::TGT_NONE;
      end
      // status read merges one open-bus bit and keeps the latch
      if (rd_a == cbd_pkg::ADDR_STATUS) begin
        res.rdata = (ob_eff & cbd_pkg::STATUS_OB_MASK) |
                    (req.ext_data & cbd_pkg::STATUS_EXT_MASK);
      end else begin
        res.rdata = ob_val;
      end
    end else if (req.cmd == cbd_pkg::CMD_WRITE) begin
      res.bus_addr = req.addr;
      ob_we        = 1'b1;
      ob_val       = req.wdata;
      priority if (req.addr <= cbd_pkg::ADDR_RAM_END) begin
        res.target = cbd_pkg::TGT_RAM;
        ram_wr     = 1'b1;
      end else if (req.addr <= cbd_pkg::ADDR_VIDEO_END) begin
        res.target    = cbd_pkg::TGT_VIDEO;
        res.ext_write = 1'b1;
      end else if (req.addr == cbd_pkg::ADDR_OAM_DMA) begin
        res.target     = cbd_pkg::TGT_OAM;
        dma_on_next    = 1'b1;
        dma_page_next  = req.wdata;
        dma_index_next = 8'd0;
        dma_wait_next  = 1'b1;
      end else if (req.addr == cbd_pkg::ADDR_PAD1) begin
        res.target    = cbd_pkg::TGT_PAD1;
        res.ext_write = 1'b1;
      end else if (req.addr <= cbd_pkg::ADDR_PAD2) begin
        res.target    = cbd_pkg::TGT_AUDIO;
        res.ext_write = 1'b1;
        if (req.addr == cbd_pkg::ADDR_STATUS) begin
          dmc_on_next   = 1'b1;
          dma_wait_next = 1'b1;
        end
      end else if (req.addr >= cbd_pkg::ADDR_CART) begin
        res.target    = cbd_pkg::TGT_CART;
        res.ext_write = 1'b1;
      end else begin
        res.target = cbd_pkg::TGT_NONE;
      end
    end else if ((req.cmd == cbd_pkg::CMD_TICK) && dma_on) begin
      // dummy phase ends on an odd tick; even ticks fetch (above), odd ticks store
      if (dma_wait) begin
        if (req.cycle_odd) begin
          dma_wait_next = 1'b0;
        end
      end else begin
        res.oam_write  = 1'b1;
        res.oam_index  = req.oam_base + dma_index;
        res.oam_data   = db_eff;
        dma_index_next = dma_index + 8'd1;
        if (dma_index == 8'hFF) begin
          dma_on_next   = 1'b0;
          dma_wait_next = 1'b1;
        end
      end
    end

    res.dma_busy = dma_on_next;
    res.dmc_flag = dmc_on_next;
  end

  // open bus and fetched byte: this transaction first, else the late ram byte
  always_comb begin
    open_bus_next = open_bus;
    dma_byte_next = dma_byte;
    if (acc && ob_we) begin
      open_bus_next = ob_val;
    end else if (ram_rd_d1) begin
      open_bus_next = ram_q;
    end
    if (acc && is_fetch && !from_ram) begin
      dma_byte_next = res.rdata;
    end else if (ram_rd_d1 && rd_dma_d1) begin
      dma_byte_next = ram_q;
    end
  end

  // sequencer and latch registers
  always_ff @(posedge clk) begin
    if (rst) begin
      open_bus  <= 8'd0;
      dma_page  <= 8'd0;
      dma_index <= 8'd0;
      dma_byte  <= 8'd0;
      dma_wait  <= 1'b0;
      dma_on    <= 1'b0;
      dmc_on    <= 1'b0;
      ram_rd_d1 <= 1'b0;
      rd_dma_d1 <= 1'b0;
    end else begin
      open_bus  <= open_bus_next;
      dma_byte  <= dma_byte_next;
      ram_rd_d1 <= acc && do_read && from_ram;
      rd_dma_d1 <= acc && is_fetch;
      if (acc) begin
        dma_page  <= dma_page_next;
        dma_index <= dma_index_next;
        dma_wait  <= dma_wait_next;
        dma_on    <= dma_on_next;
        dmc_on    <= dmc_on_next;
      end
    end
  end

  // fill pass after reset
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_done <= 1'b0;
      clr_addr <= '0;
    end else if (!clr_done) begin
      clr_addr <= clr_addr + RA_W'(1);
      if (clr_addr == RA_W'(RAM_BYTES - 1)) begin
        clr_done <= 1'b1;
      end
    end
  end

  // work ram
  assign ram_we    = !clr_done || (acc && ram_wr);
  assign ram_waddr = clr_done ? slot : clr_addr;
  assign ram_wdata = clr_done ? req.wdata : cbd_pkg::RAM_FILL;
  assign ram_re    = acc && do_read && from_ram;

  cbd_ram #(
    .WIDTH(8),
    .DEPTH(RAM_BYTES)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .re   (ram_re),
    .raddr(slot),
    .rdata(ram_q)
  );

  // middle stage waits for the ram byte
  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
    end else if (acc) begin
      b_valid <= 1'b1;
    end else if (b_move) begin
      b_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      b_res      <= res;
      b_from_ram <= from_ram;
    end
  end

  // middle stage result with the ram byte merged in
  always_comb begin
    b_out       = b_res;
    b_out.rdata = b_from_ram ? ram_q : b_res.rdata;
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else begin
      rsp_valid <= b_move || (rsp_valid && rsp_stall);
    end
  end

  always_ff @(posedge clk) begin
    if (b_move) begin
      rsp <= b_out;
    end
  end

  // checks
  `CBD_ASSERT(a_ram_byte_held, b_valid && b_from_ram && !b_move |=> $stable(ram_q), "ram byte lost")
  `CBD_ASSERT(a_idle_index_zero, !dma_on |-> dma_index == 8'd0, "index moved while idle")
  `CBD_ASSERT_ALWAYS(a_no_accept_in_fill, !clr_done |-> !acc, "accepted during ram fill")

endmodule

// ===== hdl/cbd_ram.sv =====
// generic single-port-write ram with registered read
module cbd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2048
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
